// File: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/dscmp_pkg.sv
// Package: constants, types and helper functions of the dice sum counter.
`default_nettype none

package dscmp_pkg;

    // Recurrence order (die faces) and width of the target sum
    localparam int ORDER    = 6;
    localparam int SUM_BITS = 60;

    // Residue width and modulus
    localparam int VAL_W  = 30;
    localparam int PROD_W = 2 * VAL_W;
    localparam int RED_W  = VAL_W + 2;

    localparam logic [VAL_W-1:0] WAY_MOD    = 30'd1000000007;
    localparam logic [RED_W-1:0] WAY_MOD_X2 = {1'b0, WAY_MOD, 1'b0};

    // Barrett constant floor(2^PROD_W / WAY_MOD)
    localparam logic [VAL_W:0] BARRETT_MU =
        (VAL_W + 1)'((64'd1 << PROD_W) / 64'(WAY_MOD));

    // Matrix storage: three slots of ORDER x ORDER entries
    localparam int IDX_W      = $clog2(ORDER);
    localparam int MAT_SIZE   = ORDER * ORDER;
    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = 2;
    localparam int MEM_DEPTH  = SLOT_COUNT * MAT_SIZE;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    typedef logic [VAL_W-1:0]    val_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [SUM_BITS-1:0] sum_t;

    localparam idx_t IDX_LAST = IDX_W'(ORDER - 1);

    // Slot roles after setup
    localparam slot_t SLOT_ACC_INIT  = 2'd0;
    localparam slot_t SLOT_BASE_INIT = 2'd1;
    localparam slot_t SLOT_FREE_INIT = 2'd2;

    // Memory address of one matrix entry
    function automatic addr_t mat_addr(slot_t slot, idx_t row, idx_t col);
        int a;
        a = int'(slot) * MAT_SIZE + int'(row) * ORDER + int'(col);
        return ADDR_W'(a);
    endfunction

    // Seed entry f(idx + 1) = 2^idx, always below the modulus for ORDER <= 8
    function automatic val_t seed_val(idx_t idx);
        return val_t'(1) << idx;
    endfunction

endpackage

`default_nettype wire

// File: design/dscmp_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module dscmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// File: design/dscmp_mulmod.sv
// Pipelined modular multiplier: one product a*b mod WAY_MOD per cycle, five stages.
`default_nettype none
`include "assert_macros.svh"

module dscmp_mulmod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire dscmp_pkg::val_t a,
    input  wire dscmp_pkg::val_t b,
    output logic                 out_valid,
    output dscmp_pkg::val_t      r
);
    import dscmp_pkg::*;

    logic               valid1_reg, valid2_reg, valid3_reg, valid4_reg, valid5_reg;
    logic [PROD_W-1:0]  prod1_reg;
    logic [PROD_W:0]    himu2_reg;
    logic [RED_W-1:0]   lo2_reg;
    logic [RED_W-1:0]   rem3_reg;
    logic [VAL_W:0]     rem4_reg;
    val_t               r5_reg;

    logic [PROD_W:0]    himu_next;
    logic [VAL_W-1:0]   quot;
    logic [PROD_W-1:0]  qm_full;
    logic [RED_W-1:0]   rem3_next;
    logic [VAL_W:0]     rem4_next;
    val_t               r5_next;

    // Estimate the quotient from the high half of the product
    assign himu_next = (PROD_W + 1)'(prod1_reg[PROD_W-1:VAL_W]) * (PROD_W + 1)'(BARRETT_MU);
    assign quot      = himu2_reg[PROD_W-1:VAL_W];
    assign qm_full   = PROD_W'(quot) * PROD_W'(WAY_MOD);

    // Remainder stays below four moduli, so 32 low bits suffice
    assign rem3_next = lo2_reg - qm_full[RED_W-1:0];

    // Fold the remainder down in two compare-subtract steps
    assign rem4_next = (rem3_reg >= WAY_MOD_X2) ? (VAL_W + 1)'(rem3_reg - WAY_MOD_X2)
                                                : (VAL_W + 1)'(rem3_reg);
    assign r5_next   = (rem4_reg >= {1'b0, WAY_MOD}) ? val_t'(rem4_reg - {1'b0, WAY_MOD})
                                                     : val_t'(rem4_reg);

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        prod1_reg <= PROD_W'(a) * PROD_W'(b);
        himu2_reg <= himu_next;
        lo2_reg   <= prod1_reg[RED_W-1:0];
        rem3_reg  <= rem3_next;
        rem4_reg  <= rem4_next;
        r5_reg    <= r5_next;
    end

    assign out_valid = valid5_reg;
    assign r         = r5_reg;

    `ASSERT_IMPLIES(a_first_fold_range, clk, rst_n, valid4_reg, rem4_reg < WAY_MOD_X2, "quotient estimate off by more than three")
    `ASSERT_IMPLIES(a_result_reduced, clk, rst_n, out_valid, r < WAY_MOD, "product not fully reduced")

endmodule

`default_nettype wire

// File: design/dice_sum_count_matrix_power.sv
// Top level: dice throw sequence counter by companion matrix power, modulo 1000000007.
//
// Channel  Handshake             Payload
// in       in_valid / in_ready   target_sum[59:0]
// out      out_valid / out_ready way_count[29:0]
//
// A target up to 6 gives its result in the cycle after acceptance.
// A larger one runs a setup pass that writes 72 entries, then per bit of (target - 6) a check
// and, but for the top bit, a squaring pass, per set bit a multiply pass (216 products per
// pass on the one mulmod pipeline), then a dot product.
// Reset clears the sequencer at once; there is no clearing pass.
// One transaction at a time: in_ready stays low from acceptance until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module dice_sum_count_matrix_power (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dscmp_pkg::SUM_BITS-1:0] target_sum,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [dscmp_pkg::VAL_W-1:0]       way_count
);
    import dscmp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b000_0001,
        S_INIT    = 7'b000_0010,
        S_CHECK   = 7'b000_0100,
        S_MUL_ACC = 7'b000_1000,
        S_SQUARE  = 7'b001_0000,
        S_DOT     = 7'b010_0000,
        S_DONE    = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;
    sum_t   e_reg, e_next;
    slot_t  acc_ptr_reg, acc_ptr_next;
    slot_t  base_ptr_reg, base_ptr_next;
    slot_t  free_ptr_reg, free_ptr_next;
    logic   init_sel_reg, init_sel_next;
    idx_t   iss_row_reg, iss_row_next;
    idx_t   iss_col_reg, iss_col_next;
    idx_t   iss_k_reg, iss_k_next;
    logic   issuing_reg, issuing_next;
    logic   rd_valid_reg, rd_valid_next;
    idx_t   out_row_reg, out_row_next;
    idx_t   out_col_reg, out_col_next;
    idx_t   out_k_reg, out_k_next;
    val_t   dot_seed_reg, dot_seed_next;
    val_t   sum_reg, sum_next;
    val_t   result_reg, result_next;

    // RAM and multiplier connections
    logic   wr_en;
    addr_t  wr_addr;
    val_t   wr_data;
    addr_t  rd_addr_a, rd_addr_b;
    val_t   rd_data_a, rd_data_b;
    val_t   mm_b;
    logic   mm_valid;
    val_t   mm_r;

    // Helpers
    sum_t           n_in;
    logic           dot_mode;
    logic           in_pass;
    logic           slots_distinct;
    logic           iss_last;
    logic [VAL_W:0] fold_raw;
    val_t           fold_sum;
    logic           init_one;

    assign n_in     = target_sum[SUM_BITS-1:0];
    assign dot_mode = (state_reg == S_DOT);
    assign in_pass  = (state_reg == S_MUL_ACC) || (state_reg == S_SQUARE) || dot_mode;
    assign slots_distinct = (acc_ptr_reg != base_ptr_reg) && (acc_ptr_reg != free_ptr_reg)
                            && (base_ptr_reg != free_ptr_reg);

    // Read addresses: left operand is acc (multiply, dot) or base (square); right is base
    assign rd_addr_a = mat_addr((state_reg == S_SQUARE) ? base_ptr_reg : acc_ptr_reg,
                                iss_row_reg, iss_k_reg);
    assign rd_addr_b = mat_addr(base_ptr_reg, iss_k_reg, iss_col_reg);

    assign iss_last = dot_mode ? (iss_k_reg == IDX_LAST)
                               : ((iss_k_reg == IDX_LAST) && (iss_col_reg == IDX_LAST)
                                  && (iss_row_reg == IDX_LAST));

    // Accumulate incoming products modulo WAY_MOD
    assign fold_raw = {1'b0, (out_k_reg == '0) ? val_t'(0) : sum_reg} + {1'b0, mm_r};
    assign fold_sum = (fold_raw >= {1'b0, WAY_MOD}) ? val_t'(fold_raw - {1'b0, WAY_MOD})
                                                    : val_t'(fold_raw);

    // Setup values: identity for acc, companion matrix for base
    assign init_one = init_sel_reg
                      ? ((iss_row_reg == '0) || ({1'b0, iss_row_reg} == {1'b0, iss_col_reg} + 1'b1))
                      : (iss_row_reg == iss_col_reg);

    assign mm_b = dot_mode ? dot_seed_reg : rd_data_b;

    always_comb
    begin
        state_next    = state_reg;
        e_next        = e_reg;
        acc_ptr_next  = acc_ptr_reg;
        base_ptr_next = base_ptr_reg;
        free_ptr_next = free_ptr_reg;
        init_sel_next = init_sel_reg;
        iss_row_next  = iss_row_reg;
        iss_col_next  = iss_col_reg;
        iss_k_next    = iss_k_reg;
        issuing_next  = issuing_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_k_next    = out_k_reg;
        dot_seed_next = dot_seed_reg;
        sum_next      = sum_reg;
        result_next   = result_reg;
        rd_valid_next = issuing_reg;
        wr_en         = 1'b0;
        wr_addr       = mat_addr(free_ptr_reg, out_row_reg, out_col_reg);
        wr_data       = fold_sum;

        // Issue one operand pair per cycle, k innermost
        if (issuing_reg)
        begin
            dot_seed_next = seed_val(IDX_LAST - iss_k_reg);
            if (iss_k_reg == IDX_LAST)
            begin
                iss_k_next = '0;
                if (iss_col_reg == IDX_LAST)
                begin
                    iss_col_next = '0;
                    iss_row_next = (iss_row_reg == IDX_LAST) ? idx_t'(0) : iss_row_reg + 1'b1;
                end
                else
                begin
                    iss_col_next = iss_col_reg + 1'b1;
                end
            end
            else
            begin
                iss_k_next = iss_k_reg + 1'b1;
            end
            if (iss_last)
            begin
                issuing_next = 1'b0;
            end
        end

        // Drain products in issue order
        if (mm_valid)
        begin
            sum_next = fold_sum;
            if (out_k_reg == IDX_LAST)
            begin
                out_k_next = '0;
                if (out_col_reg == IDX_LAST)
                begin
                    out_col_next = '0;
                    out_row_next = (out_row_reg == IDX_LAST) ? idx_t'(0) : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            else
            begin
                out_k_next = out_k_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (n_in <= SUM_BITS'(ORDER))
                    begin
                        result_next = (n_in == '0) ? val_t'(1)
                                                   : seed_val(n_in[IDX_W-1:0] - IDX_W'(1));
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        e_next        = n_in - SUM_BITS'(ORDER);
                        acc_ptr_next  = SLOT_ACC_INIT;
                        base_ptr_next = SLOT_BASE_INIT;
                        free_ptr_next = SLOT_FREE_INIT;
                        init_sel_next = 1'b0;
                        iss_row_next  = '0;
                        iss_col_next  = '0;
                        state_next    = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                // Write one setup entry per cycle
                wr_en   = 1'b1;
                wr_addr = mat_addr(init_sel_reg ? base_ptr_reg : acc_ptr_reg,
                                   iss_row_reg, iss_col_reg);
                wr_data = val_t'(init_one);
                if (iss_col_reg == IDX_LAST)
                begin
                    iss_col_next = '0;
                    if (iss_row_reg == IDX_LAST)
                    begin
                        iss_row_next  = '0;
                        init_sel_next = 1'b1;
                        if (init_sel_reg)
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        iss_row_next = iss_row_reg + 1'b1;
                    end
                end
                else
                begin
                    iss_col_next = iss_col_reg + 1'b1;
                end
            end

            S_CHECK:
            begin
                // Pick the next pass from the exponent: dot product once it is zero, else by its low bit
                priority if (e_reg == '0)
                begin
                    state_next = S_DOT;
                end
                else if (e_reg[0])
                begin
                    state_next = S_MUL_ACC;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
                iss_row_next = '0;
                iss_col_next = '0;
                iss_k_next   = '0;
                out_row_next = '0;
                out_col_next = '0;
                out_k_next   = '0;
                issuing_next = 1'b1;
            end

            S_MUL_ACC:
            begin
                if (mm_valid && (out_k_reg == IDX_LAST))
                begin
                    wr_en = 1'b1;
                    if ((out_row_reg == IDX_LAST) && (out_col_reg == IDX_LAST))
                    begin
                        // Product lands in the free slot: swap it with acc
                        acc_ptr_next  = free_ptr_reg;
                        free_ptr_next = acc_ptr_reg;
                        state_next    = (e_reg[SUM_BITS-1:1] == '0) ? S_DOT : S_SQUARE;
                        iss_row_next  = '0;
                        iss_col_next  = '0;
                        iss_k_next    = '0;
                        out_row_next  = '0;
                        out_col_next  = '0;
                        out_k_next    = '0;
                        issuing_next  = 1'b1;
                    end
                end
            end

            S_SQUARE:
            begin
                if (mm_valid && (out_k_reg == IDX_LAST))
                begin
                    wr_en = 1'b1;
                    if ((out_row_reg == IDX_LAST) && (out_col_reg == IDX_LAST))
                    begin
                        // Square lands in the free slot: swap it with base, drop one bit
                        base_ptr_next = free_ptr_reg;
                        free_ptr_next = base_ptr_reg;
                        e_next        = e_reg >> 1;
                        state_next    = S_CHECK;
                    end
                end
            end

            S_DOT:
            begin
                if (mm_valid && (out_k_reg == IDX_LAST))
                begin
                    result_next = fold_sum;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            acc_ptr_reg  <= SLOT_ACC_INIT;
            base_ptr_reg <= SLOT_BASE_INIT;
            free_ptr_reg <= SLOT_FREE_INIT;
            init_sel_reg <= 1'b0;
            iss_row_reg  <= '0;
            iss_col_reg  <= '0;
            iss_k_reg    <= '0;
            issuing_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_k_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_ptr_reg  <= acc_ptr_next;
            base_ptr_reg <= base_ptr_next;
            free_ptr_reg <= free_ptr_next;
            init_sel_reg <= init_sel_next;
            iss_row_reg  <= iss_row_next;
            iss_col_reg  <= iss_col_next;
            iss_k_reg    <= iss_k_next;
            issuing_reg  <= issuing_next;
            rd_valid_reg <= rd_valid_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_k_reg    <= out_k_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        dot_seed_reg <= dot_seed_next;
        sum_reg      <= sum_next;
        result_reg   <= result_next;
    end

    dscmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    dscmp_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .a         (rd_data_a),
        .b         (mm_b),
        .out_valid (mm_valid),
        .r         (mm_r)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign way_count = result_reg;

    `ASSERT_ALWAYS(a_slots_distinct, clk, rst_n, slots_distinct, "matrix slots overlap")
    `ASSERT_IMPLIES(a_products_in_pass, clk, rst_n, mm_valid || rd_valid_reg, in_pass, "product outside a pass")
    `ASSERT_IMPLIES(a_result_reduced, clk, rst_n, out_valid, way_count < WAY_MOD, "result not reduced")

endmodule

`default_nettype wire

// File: tb/tb_dice_sum_count_matrix_power.sv
// Testbench for the dice throw sequence counter: randomized targets checked against a matrix-power predictor.
`timescale 1ns / 100ps

module tb_dice_sum_count_matrix_power;
    import dscmp_pkg::*;

    localparam int  CLK_PERIOD  = 4;
    localparam int  RESET_CYCLES = 10;
    localparam int  RANDOM_SUMS = 81;
    localparam int  DRAIN_CYCLES = 20;
    localparam longint unsigned COUNT_MOD = 64'(WAY_MOD);

    // One pending result: the target that caused it and the count it must carry
    typedef struct {
        sum_t target;
        val_t ways;
    } way_rec_t;

    // Scoreboard: predicts the way count of every accepted target and checks results in order
    class way_count_board;
        way_rec_t        pending_counts[$];
        int              mismatches = 0;
        int              checked = 0;
        longint unsigned acc_m  [ORDER][ORDER];
        longint unsigned base_m [ORDER][ORDER];

        // Replace acc or base by its product with base, every entry reduced
        function void mat_product(bit into_acc);
            longint unsigned prod_m [ORDER][ORDER];
            longint unsigned sum;
            for (int i = 0; i < ORDER; i++)
                for (int j = 0; j < ORDER; j++)
                begin
                    sum = 0;
                    for (int k = 0; k < ORDER; k++)
                        sum = (sum + (into_acc ? acc_m[i][k] : base_m[i][k]) * base_m[k][j])
                              % COUNT_MOD;
                    prod_m[i][j] = sum;
                end
            for (int i = 0; i < ORDER; i++)
                for (int j = 0; j < ORDER; j++)
                    if (into_acc)
                        acc_m[i][j] = prod_m[i][j];
                    else
                        base_m[i][j] = prod_m[i][j];
        endfunction

        // Number of ordered throw sequences that add up to n, modulo the prime
        function val_t count_ways(sum_t n);
            longint unsigned pow_left;
            longint unsigned total;
            if (n == 0)
                return val_t'(1);
            if (n <= ORDER)
                return val_t'(1) << (n - 1);
            // Companion matrix in base, identity in acc
            for (int i = 0; i < ORDER; i++)
                for (int j = 0; j < ORDER; j++)
                begin
                    base_m[i][j] = (i == 0 || i == j + 1) ? 1 : 0;
                    acc_m[i][j]  = (i == j) ? 1 : 0;
                end
            pow_left = 64'(n) - ORDER;
            while (pow_left != 0)
            begin
                if (pow_left[0])
                    mat_product(1'b1);
                mat_product(1'b0);
                pow_left = pow_left >> 1;
            end
            // Dot the first row with the seed vector, top entry first
            total = 0;
            for (int i = 0; i < ORDER; i++)
                total = (total + acc_m[0][i] * (64'd1 << (ORDER - 1 - i))) % COUNT_MOD;
            return val_t'(total);
        endfunction

        // Record an accepted target and its predicted count
        function void note_sum(sum_t n);
            way_rec_t rec;
            rec.target = n;
            rec.ways   = count_ways(n);
            pending_counts.push_back(rec);
        endfunction

        // Compare a delivered count with the oldest prediction
        function void check_count(val_t got);
            way_rec_t rec;
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                $display("%0t: way_count with no pending target: expected none, actual %0d",
                         $time, got);
                return;
            end
            rec = pending_counts.pop_front();
            checked++;
            if (got !== rec.ways)
            begin
                mismatches++;
                $display("%0t: way_count for target %0d: expected %0d, actual %0d",
                         $time, rec.target, rec.ways, got);
            end
        endfunction

        function int outstanding();
            return pending_counts.size();
        endfunction
    endclass

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic in_valid   = 1'b0;
    logic in_ready;
    sum_t target_sum = '0;
    logic out_valid;
    logic out_ready  = 1'b0;
    val_t way_count;

    int tx_idle_pct = 26;
    int rx_idle_pct = 66;
    int sent_sums   = 0;
    int wide_sums   = 0;

    way_count_board board = new;

    dice_sum_count_matrix_power uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .target_sum (target_sum),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .way_count  (way_count)
    );

    // Free-running clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the result channel at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Check every result transaction
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_count(way_count);

    // Offer one target after a random gap; return at the falling edge after acceptance
    task automatic send_sum(input sum_t n);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid   <= 1'b0;
            target_sum <= sum_t'({$urandom, $urandom});
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        target_sum <= n;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sum(n);
        sent_sums++;
        if (n >= (64'd1 << 16))
            wide_sums++;
        @(negedge clk);
    endtask

    // Draw a target: mostly narrow, now and then full width or a small value up to 12
    function automatic sum_t pick_sum();
        sum_t raw;
        int   bits;
        raw = sum_t'({$urandom, $urandom});
        if ($urandom_range(0, 5) == 0)
            return sum_t'($urandom_range(0, 12));
        if ($urandom_range(0, 11) == 0)
            return raw;
        bits = $urandom_range(1, 14);
        return raw & ((sum_t'(1) << bits) - 1);
    endfunction

    // Main sequence
    initial
    begin
        sum_t directed_sums[$];
        directed_sums = '{
            60'd0, 60'd1, 60'd2, 60'd3, 60'd4, 60'd5, 60'd6, 60'd7, 60'd8, 60'd9,
            60'd12, 60'd13, 60'd70, 60'd1000, 60'd1048582,
            60'h800_0000_0000_0000, 60'hFFF_FFFF_FFFF_FFFF,
            60'hAAA_AAAA_AAAA_AAAA, 60'h555_5555_5555_5555
        };

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed targets: seed range, first matrix cases, extremes
        foreach (directed_sums[i])
            send_sum(directed_sums[i]);

        // Random targets over three idle patterns
        for (int i = 0; i < RANDOM_SUMS; i++)
        begin
            if (i == RANDOM_SUMS / 3)
            begin
                tx_idle_pct = 66;
                rx_idle_pct = 26;
            end
            else if (i == 2 * RANDOM_SUMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_sum(pick_sum());
        end
        in_valid <= 1'b0;

        // Drain outstanding results
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d targets (%0d of 17 bits or more), checked %0d way counts",
                 sent_sums, wide_sums, board.checked);
        $display("Idle patterns: sender-light, receiver-light, and back-to-back");
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #80_000_000;
        $display("Timeout with %0d results outstanding", board.outstanding());
        $display("Mismatches found");
        $finish;
    end

endmodule
